// ===== design/cst_pkg.sv =====
package cst_pkg;

  localparam int NumSems   = 16;
  localparam int NumProcs  = 16;
  localparam int SemIdxW   = (NumSems > 1) ? $clog2(NumSems) : 1;
  localparam int RingIdxW  = (NumProcs > 1) ? $clog2(NumProcs) : 1;
  localparam int RingDepth = NumSems * NumProcs;
  localparam int RingAddrW = SemIdxW + RingIdxW;
  localparam int CountW    = 16;
  localparam int PidW      = 8;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_WAIT   = 2'd1,
    REQ_SIGNAL = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pid;
    logic [3:0]  sem_id;
    logic [14:0] init_value;
  } sem_req_t;

  typedef struct packed {
    logic       status;
    logic [3:0] alloc_id;
    logic       block_now;
    logic       unblock_now;
    logic [7:0] unblock_pid;
  } sem_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic read;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== design/counting_semaphore_table_core.sv =====
// Counting semaphore table: 16 semaphores, each with a 16-entry FIFO ring of
// waiting process ids.
// Request channel: drive req_i with start high; the item is taken at a rising
// edge where start is high and busy is low. busy stays high while the item is
// in flight, through the read and execute states.
// Item kinds: allocate claims the lowest free entry and loads its count;
// wait decrements and queues the pid when the count goes negative; signal
// increments and pops the oldest pid when the count is not above zero.
// Result channel: done_o is high for one cycle with rsp_o; done_o is registered
// from the execute state, and the result is taken at the edge where it is high.
// The receiver cannot stall it.
// Steps: the read state reads the ring slot at the head of the addressed
// semaphore from the ring RAM (registered read); the execute state does the
// read-modify-write of the count, pointers and ring slot; back in idle, the
// result is shown and only then can a new item be taken, at its closing edge.
// Reset: all entries free, counts and ring pointers zero. Ring contents are
// not cleared on reset or on allocate; popping a slot never written returns
// an arbitrary pid.
module counting_semaphore_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cst_pkg::sem_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output cst_pkg::sem_rsp_t rsp_o
);
  import cst_pkg::*;

  dp_cmd_t cmd;

  cst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  cst_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // every accepted item is followed by its result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result did not follow accepted item");

  // controller is back in idle when the result is shown
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // a full-table failure never also blocks or releases
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |-> (!rsp_o.block_now && !rsp_o.unblock_now))
    else $error("status error with block or unblock");

  // block and unblock never in one result
  a_blk_unblk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.block_now && rsp_o.unblock_now))
    else $error("block and unblock together");

endmodule

// ===== design/cst_ctrl.sv =====
module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output cst_pkg::dp_cmd_t cmd_o
);
  import cst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    busy_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/cst_dp.sv =====
module cst_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cst_pkg::dp_cmd_t  cmd_i,
  input  cst_pkg::sem_req_t req_i,
  output logic              done_o,
  output cst_pkg::sem_rsp_t rsp_o
);
  import cst_pkg::*;

  sem_req_t req_q;

  logic                in_use_q [NumSems];
  logic [CountW-1:0]   count_q  [NumSems];
  logic [RingIdxW-1:0] head_q   [NumSems];
  logic [RingIdxW-1:0] tail_q   [NumSems];

  logic [PidW-1:0]     ring_mem [RingDepth];
  logic [PidW-1:0]     ring_rd_q;

  logic                done_q;
  sem_rsp_t            rsp_q, rsp_d;

  logic [SemIdxW-1:0]  sid;
  logic                sid_ok;
  logic [SemIdxW-1:0]  free_idx;
  logic                free_found;
  logic [CountW-1:0]   cnt_dec, cnt_inc;
  logic [RingAddrW-1:0] rd_addr, wr_addr;

  // table update controls
  logic                alloc_we, count_we, head_we, tail_we, ring_we;
  logic [CountW-1:0]   count_new;

  assign sid     = req_q.sem_id[SemIdxW-1:0];
  assign sid_ok  = (32'(req_q.sem_id) < NumSems);
  assign cnt_dec = count_q[sid] - CountW'(1);
  assign cnt_inc = count_q[sid] + CountW'(1);
  assign rd_addr = {sid, head_q[sid]};
  assign wr_addr = {sid, tail_q[sid]};

  // lowest free entry
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NumSems - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = SemIdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    rsp_d     = '0;
    alloc_we  = 1'b0;
    count_we  = 1'b0;
    head_we   = 1'b0;
    tail_we   = 1'b0;
    ring_we   = 1'b0;
    count_new = cnt_dec;
    unique case (req_q.req_type)
      REQ_ALLOC: begin
        if (free_found) begin
          alloc_we       = 1'b1;
          rsp_d.alloc_id = 4'(free_idx);
        end else begin
          rsp_d.status = 1'b1;
        end
      end
      REQ_WAIT: begin
        if (sid_ok) begin
          count_we  = 1'b1;
          count_new = cnt_dec;
          if (cnt_dec[CountW-1]) begin
            ring_we         = 1'b1;
            tail_we         = 1'b1;
            rsp_d.block_now = 1'b1;
          end
        end
      end
      REQ_SIGNAL: begin
        if (sid_ok) begin
          count_we  = 1'b1;
          count_new = cnt_inc;
          if (cnt_inc[CountW-1] || (cnt_inc == '0)) begin
            head_we           = 1'b1;
            rsp_d.unblock_now = 1'b1;
            rsp_d.unblock_pid = ring_rd_q;
          end
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  // wait ring storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ring_we) begin
      ring_mem[wr_addr] <= req_q.pid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      ring_rd_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      for (int i = 0; i < NumSems; i++) begin
        in_use_q[i] <= 1'b0;
        count_q[i]  <= '0;
        head_q[i]   <= '0;
        tail_q[i]   <= '0;
      end
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        if (alloc_we) begin
          in_use_q[free_idx] <= 1'b1;
          count_q[free_idx]  <= CountW'(req_q.init_value);
          head_q[free_idx]   <= '0;
          tail_q[free_idx]   <= '0;
        end
        if (count_we) begin
          count_q[sid] <= count_new;
        end
        if (tail_we) begin
          tail_q[sid] <= tail_q[sid] + RingIdxW'(1);
        end
        if (head_we) begin
          head_q[sid] <= head_q[sid] + RingIdxW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/sv/sem_table_checker.sv =====
`timescale 1ns / 1ps
module sem_table_checker
  import cst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  sem_req_t req_i,
  input  logic     done_i,
  input  sem_rsp_t rsp_i,
  output int       errors_o,
  output int       pending_o,
  output int       checked_o
);

  // predicted table state
  logic                taken   [NumSems];
  logic [CountW-1:0]   count   [NumSems];
  logic [RingIdxW-1:0] head    [NumSems];
  logic [RingIdxW-1:0] tail    [NumSems];
  logic [PidW-1:0]     waiters [NumSems][NumProcs];

  sem_rsp_t rsp_q[$];
  sem_rsp_t want;

  function automatic sem_rsp_t serve(sem_req_t r);
    sem_rsp_t           o;
    logic [SemIdxW-1:0] s;
    bit                 found;
    o     = '0;
    s     = '0;
    found = 1'b0;
    case (r.req_type)
      REQ_ALLOC: begin
        for (int k = 0; k < NumSems; k++) begin
          if (!found && !taken[k]) begin
            found = 1'b1;
            s     = k[SemIdxW-1:0];
          end
        end
        if (!found) begin
          o.status = 1'b1;
        end else begin
          taken[s] = 1'b1;
          count[s] = CountW'(r.init_value);
          head[s]  = '0;
          tail[s]  = '0;
          // slots read as unknown until written again
          for (int j = 0; j < NumProcs; j++) waiters[s][j] = 'x;
          o.alloc_id = s;
        end
      end
      REQ_WAIT: begin
        s        = r.sem_id;
        count[s] = count[s] - CountW'(1);
        if (count[s][CountW-1]) begin
          waiters[s][tail[s]] = r.pid;
          tail[s]             = tail[s] + RingIdxW'(1);
          o.block_now         = 1'b1;
        end
      end
      REQ_SIGNAL: begin
        s        = r.sem_id;
        count[s] = count[s] + CountW'(1);
        if (count[s][CountW-1] || count[s] == '0) begin
          o.unblock_pid = waiters[s][head[s]];
          head[s]       = head[s] + RingIdxW'(1);
          o.unblock_now = 1'b1;
        end
      end
      default: ;  // unknown kind: all fields zero
    endcase
    return o;
  endfunction

  // an unknown expected value is a pop of a slot nobody wrote: not compared
  function automatic void cmp(string field, logic [7:0] exp_v, logic [7:0] got_v);
    if (!$isunknown(exp_v) && got_v !== exp_v) begin
      errors_o++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSems; k++) begin
        taken[k] = 1'b0;
        count[k] = '0;
        head[k]  = '0;
        tail[k]  = '0;
        for (int j = 0; j < NumProcs; j++) waiters[k][j] = 'x;
      end
      rsp_q.delete();
      errors_o  = 0;
      checked_o = 0;
      pending_o <= 0;
    end else begin
      // a result and a new item can share an edge; the result is older
      if (done_i) begin
        if (rsp_q.size() == 0) begin
          errors_o++;
          $display("%0t: result 0x%0h with no item outstanding", $time, rsp_i);
        end else begin
          want = rsp_q.pop_front();
          cmp("status", want.status, rsp_i.status);
          cmp("alloc_id", want.alloc_id, rsp_i.alloc_id);
          cmp("block_now", want.block_now, rsp_i.block_now);
          cmp("unblock_now", want.unblock_now, rsp_i.unblock_now);
          cmp("unblock_pid", want.unblock_pid, rsp_i.unblock_pid);
          checked_o++;
        end
      end
      if (start_i && !busy_i) rsp_q.push_back(serve(req_i));
      pending_o <= rsp_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cst_pkg::*;

  // request kind the block does not know; it must answer with all fields zero
  localparam logic [1:0] ReqUnknown = 2'd3;

  localparam int RandomItems = 1650;
  localparam int ResetCycles = 11;
  // Longest quiet stretch in a good run is a run of idle draws at 52 percent
  // plus a settle; 1000 is far beyond that.
  localparam int WatchdogLimit = 1000;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  sem_req_t req   = '0;
  logic     busy;
  logic     done;
  sem_rsp_t rsp;

  int errors;
  int pending;
  int checked;
  int idle_pct     = 0;
  int stall_cycles = 0;

  // Occupancy tracking for stimulus only: which ring slots hold a pid written
  // since the last allocate, so a random signal never pops a slot nobody wrote.
  logic [NumSems-1:0]  trk_taken;
  logic [CountW-1:0]   trk_count  [NumSems];
  logic [RingIdxW-1:0] trk_head   [NumSems];
  logic [RingIdxW-1:0] trk_tail   [NumSems];
  logic [NumProcs-1:0] trk_filled [NumSems];

  int n_alloc, n_wait, n_signal, n_unknown;
  int n_refused, n_block, n_release, n_wrap;

  always #5 clk = ~clk;

  counting_semaphore_table_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  sem_table_checker u_sem_chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .busy_i    (busy),
    .req_i     (req),
    .done_i    (done),
    .rsp_i     (rsp),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  // Watchdog: any edge with an accepted item or a result resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic sem_req_t mk_req(logic [1:0] kind, logic [7:0] pid, logic [3:0] sem,
                                      logic [14:0] init);
    sem_req_t r;
    r.req_type   = kind;
    r.pid        = pid;
    r.sem_id     = sem;
    r.init_value = init;
    return r;
  endfunction

  // A signal is fine unless it pops (count ends up not above zero) from a slot
  // that has not been written since the entry was last allocated.
  function automatic bit pop_is_defined(logic [3:0] s);
    logic [CountW-1:0] nxt;
    nxt = trk_count[s] + CountW'(1);
    return !(nxt[CountW-1] || nxt == '0) || trk_filled[s][trk_head[s]];
  endfunction

  // Bookkeeping of an accepted item, in issue order.
  function automatic void track(sem_req_t r);
    logic [3:0] s;
    bit         got;
    s   = r.sem_id;
    got = 1'b0;
    case (r.req_type)
      REQ_ALLOC: begin
        n_alloc++;
        for (int k = 0; k < NumSems; k++) begin
          if (!got && !trk_taken[k]) begin
            got = 1'b1;
            s   = k[3:0];
          end
        end
        if (!got) begin
          n_refused++;
        end else begin
          trk_taken[s]  = 1'b1;
          trk_count[s]  = CountW'(r.init_value);
          trk_head[s]   = '0;
          trk_tail[s]   = '0;
          trk_filled[s] = '0;
        end
      end
      REQ_WAIT: begin
        n_wait++;
        trk_count[s] = trk_count[s] - CountW'(1);
        if (trk_count[s] == 16'h7fff) n_wrap++;  // most negative back to most positive
        if (trk_count[s][CountW-1]) begin
          trk_filled[s][trk_tail[s]] = 1'b1;
          trk_tail[s]                = trk_tail[s] + RingIdxW'(1);
          n_block++;
        end
      end
      REQ_SIGNAL: begin
        n_signal++;
        trk_count[s] = trk_count[s] + CountW'(1);
        if (trk_count[s] == 16'h8000) n_wrap++;  // most positive over to most negative
        if (trk_count[s][CountW-1] || trk_count[s] == '0) begin
          trk_head[s] = trk_head[s] + RingIdxW'(1);
          n_release++;
        end
      end
      default: n_unknown++;
    endcase
  endfunction

  // Random item. Entry 2 gets about half the traffic so its count swings far
  // negative (ring wrap) and back; 3 and 15 get a share, the rest is spread.
  function automatic sem_req_t pick_item(int wait_pct);
    sem_req_t   r;
    int         roll;
    logic [3:0] s;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: s = 4'd2;
      4:          s = 4'd3;
      5:          s = 4'd15;
      default:    s = 4'($urandom_range(0, 15));
    endcase
    r = mk_req(REQ_WAIT, 8'($urandom_range(0, 255)), s, 15'($urandom_range(0, 32767)));
    if (roll < 6) begin
      r.req_type = REQ_ALLOC;    // table is full by now: exercises the refusal
    end else if (roll < 10) begin
      r.req_type = ReqUnknown;
    end else if ($urandom_range(0, 99) >= wait_pct && pop_is_defined(s)) begin
      r.req_type = REQ_SIGNAL;
    end
    return r;
  endfunction

  // Present one item; random idle cycles first, start stays high while busy.
  task automatic issue_item(input sem_req_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    track(it);
  endtask

  // Hold off until every outstanding item has been answered.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    sem_req_t it;
    int       counted;
    trk_taken = '0;
    for (int k = 0; k < NumSems; k++) begin
      trk_count[k]  = '0;
      trk_head[k]   = '0;
      trk_tail[k]   = '0;
      trk_filled[k] = '0;
    end
    {n_alloc, n_wait, n_signal, n_unknown} = '0;
    {n_refused, n_block, n_release, n_wrap} = '0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // unknown kind with every field at its maximum
    issue_item(mk_req(ReqUnknown, 8'hff, 4'hf, 15'h7fff));
    // entry 15 is not allocated yet but still works; leave its pointers off zero
    issue_item(mk_req(REQ_WAIT, 8'hff, 4'hf, 15'h0000));
    issue_item(mk_req(REQ_WAIT, 8'h00, 4'hf, 15'h7fff));
    issue_item(mk_req(REQ_SIGNAL, 8'h00, 4'hf, 15'h0000));
    // lowest free entries, extreme initial counts
    issue_item(mk_req(REQ_ALLOC, 8'h00, 4'h0, 15'h0000));
    issue_item(mk_req(REQ_ALLOC, 8'hff, 4'hf, 15'h7fff));
    issue_item(mk_req(REQ_WAIT, 8'h5a, 4'h1, 15'h2aaa));
    // block then release on entry 0
    issue_item(mk_req(REQ_WAIT, 8'h00, 4'h0, 15'h5555));
    issue_item(mk_req(REQ_SIGNAL, 8'hff, 4'h0, 15'h0000));
    // fill the table; last one is entry 15, then one refused allocate
    for (int k = 2; k < NumSems; k++) begin
      issue_item(mk_req(REQ_ALLOC, 8'(k), 4'(k), (k == NumSems - 1) ? 15'd0
                                                   : 15'($urandom_range(0, 2))));
    end
    issue_item(mk_req(REQ_ALLOC, 8'h33, 4'h7, 15'h5555));
    // allocate must have reset entry 15's ring pointers: first pid in, first out
    issue_item(mk_req(REQ_WAIT, 8'h3c, 4'hf, 15'h0000));
    issue_item(mk_req(REQ_WAIT, 8'hc3, 4'hf, 15'h0000));
    issue_item(mk_req(REQ_SIGNAL, 8'h00, 4'hf, 15'h0000));

    // ---- ring wrap on entry 0, count wrap on entry 1 ----
    // Sixteen blocking waits fill every ring slot of entry 0 and bring its
    // tail back around to where it started.
    repeat (NumProcs) begin
      issue_item(mk_req(REQ_WAIT, 8'($urandom_range(0, 255)), 4'h0,
                        15'($urandom_range(0, 32767))));
    end
    // Entry 1 sits one below the positive limit. The second signal crosses it
    // and pops a slot nobody wrote, so only its flags are checked.
    issue_item(mk_req(REQ_SIGNAL, 8'h11, 4'h1, 15'h0000));
    issue_item(mk_req(REQ_SIGNAL, 8'h88, 4'h1, 15'h0000));  // wraps, pops
    issue_item(mk_req(REQ_WAIT, 8'h77, 4'h1, 15'h0000));    // wraps back, no block
    settle();

    // ---- random phases ----
    // 0: back to back; 1: sender idle 52%; 2: receiver phase, which has no
    // effect since results cannot be held off; 3: sender idle 24%.
    // Wait-heavy and signal-heavy windows of 100 items alternate.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 52 : (ph == 3) ? 24 : 0;
      counted  = 0;
      while (counted < (RandomItems + 3) / 4) begin
        it = pick_item(((counted / 100) % 2 == 0) ? 75 : 30);
        issue_item(it);
        counted++;
      end
      settle();
    end

    settle();
    repeat (8) @(posedge clk);

    $display("tb: %0d items: %0d allocate (%0d refused), %0d wait, %0d signal, %0d unknown",
             n_alloc + n_wait + n_signal + n_unknown, n_alloc, n_refused, n_wait, n_signal,
             n_unknown);
    $display("tb: %0d results checked, %0d blocks, %0d releases, %0d count wraps",
             checked, n_block, n_release, n_wrap);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
